// ----- rtl/lsd_pkg.sv -----
// Shared types, command codes and LED/segment tables for the LED and
// seven-segment shift driver. No dependencies.
package lsd_pkg;

    localparam int IMAGE_BITS = 24;
    localparam int POS_BITS   = 5;
    localparam int SEGS       = 7;
    localparam int QDEPTH     = 2;

    typedef logic [IMAGE_BITS-1:0] image_t;   // byte 2 in [23:16], byte 0 in [7:0]
    typedef logic [POS_BITS-1:0]   pos_t;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_LED   = 2'd1,
        FUNC_DIGIT = 2'd2,
        FUNC_APPLY = 2'd3
    } func_t;

    // Snapshot handed from the command front to the queue
    typedef struct packed {
        logic   valid;
        image_t data;
    } push_t;

    // Queue status seen by the front, the back and the top level
    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] level;
    } qstat_t;

    localparam pos_t LAST_BIT = pos_t'(IMAGE_BITS - 1);

    // Flat image bit of an LED number; out of range lands on byte 0 bit 0
    function automatic pos_t led_pos(input logic [4:0] n);
        pos_t p;
        if (n >= 5'd1 && n <= 5'd5) begin
            p = 5'd6 - n;
        end else if (n >= 5'd6 && n <= 5'd12) begin
            p = 5'd21 - n;
        end else if (n >= 5'd13 && n <= 5'd19) begin
            p = 5'(6'd36 - {1'b0, n});
        end else begin
            p = 5'd0;
        end
        return p;
    endfunction

    // Segment pattern, bit 0 = segment a; blank above nine
    function automatic logic [SEGS-1:0] seg_decode(input logic [3:0] v);
        logic [SEGS-1:0] m;
        case (v)
            4'd0:    m = 7'h3F;
            4'd1:    m = 7'h06;
            4'd2:    m = 7'h5B;
            4'd3:    m = 7'h4F;
            4'd4:    m = 7'h66;
            4'd5:    m = 7'h6D;
            4'd6:    m = 7'h7D;
            4'd7:    m = 7'h07;
            4'd8:    m = 7'h7F;
            4'd9:    m = 7'h6F;
            default: m = 7'h00;
        endcase
        return m;
    endfunction

    // LED number of segment s (a..g) for the left or right digit
    function automatic logic [4:0] seg_led(input logic right, input logic [2:0] s);
        logic [4:0] n;
        case (s)
            3'd0:    n = right ? 5'd13 : 5'd6;
            3'd1:    n = right ? 5'd15 : 5'd8;
            3'd2:    n = right ? 5'd18 : 5'd11;
            3'd3:    n = right ? 5'd19 : 5'd12;
            3'd4:    n = right ? 5'd17 : 5'd10;
            3'd5:    n = right ? 5'd14 : 5'd7;
            default: n = right ? 5'd16 : 5'd9;
        endcase
        return n;
    endfunction

endpackage

// ----- rtl/lsd_front.sv -----
// Command front: accepts transactions, keeps the 24-bit image and pushes a
// snapshot into the queue on apply. Depends on lsd_pkg.
module lsd_front import lsd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [4:0] s_led_index,
    input  logic       s_led_on,
    input  logic       s_digit_select,
    input  logic [3:0] s_digit_value,
    input  qstat_t     qstat,
    output push_t      push
);

    image_t image_reg;
    image_t image_next;
    logic   accept;
    func_t  func;
    logic [SEGS-1:0] mask;

    assign s_ready = !qstat.full;
    assign accept  = s_valid && s_ready;
    assign func    = func_t'(s_func);
    assign mask    = seg_decode(s_digit_value);

    // Decode the command into the next image
    always_comb begin
        image_next = image_reg;
        unique case (func)
            FUNC_CLEAR: image_next = '0;
            FUNC_LED:   image_next[led_pos(s_led_index)] = s_led_on;
            FUNC_DIGIT: begin
                for (int s = 0; s < SEGS; s++) begin
                    image_next[led_pos(seg_led(s_digit_select, 3'(s)))] = mask[s];
                end
            end
            FUNC_APPLY: image_next = image_reg;
            default:    image_next = image_reg;
        endcase
    end

    // Hold the image; update on every accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_reg <= '0;
        end else if (accept) begin
            image_reg <= image_next;
        end
    end

    // Snapshot the image as it stands when apply arrives
    assign push.valid = accept && (func == FUNC_APPLY);
    assign push.data  = image_reg;

endmodule

// ----- rtl/lsd_queue.sv -----
// Two-entry snapshot queue between the command front and the serializer.
// Depends on lsd_pkg.
module lsd_queue import lsd_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  push_t  push,
    input  logic   pop,
    output image_t rd_data,
    output qstat_t qstat
);

    image_t     entry_reg [QDEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] level_reg;
    logic [1:0] level_next;

    assign level_next  = level_reg + {1'b0, push.valid} - {1'b0, pop};
    assign qstat.level = level_reg;
    assign qstat.full  = (level_reg == 2'(QDEPTH));
    assign qstat.empty = (level_reg == 2'd0);
    assign rd_data     = entry_reg[rd_ptr_reg];

    // Store pushed snapshots
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entry_reg[wr_ptr_reg] <= push.data;
        end
    end

    // Advance pointers and level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end else begin
            if (push.valid) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)        rd_ptr_reg <= !rd_ptr_reg;
            level_reg <= level_next;
        end
    end

endmodule

// ----- rtl/lsd_back.sv -----
// Serializer back end: pops snapshots and sends 24 bits, MSB of byte 2
// first, through a registered output. Depends on lsd_pkg.
module lsd_back import lsd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  image_t     rd_data,
    input  qstat_t     qstat,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_serial_bit,
    output logic [4:0] m_bit_number,
    output logic       m_latch_last
);

    logic   busy_reg;
    image_t shift_reg;
    pos_t   count_reg;
    logic   advance;
    logic   last;

    assign m_valid      = busy_reg;
    assign m_serial_bit = shift_reg[IMAGE_BITS-1];
    assign m_bit_number = count_reg;
    assign last         = (count_reg == LAST_BIT);
    assign m_latch_last = last;
    assign advance      = busy_reg && m_ready;

    // Load a new snapshot when idle or right after the last bit goes out
    assign pop = !qstat.empty && (!busy_reg || (advance && last));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else if (pop) begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
            shift_reg <= rd_data;
        end else if (advance) begin
            if (last) begin
                busy_reg <= 1'b0;
            end else begin
                count_reg <= count_reg + 5'd1;
                shift_reg <= {shift_reg[IMAGE_BITS-2:0], 1'b0};
            end
        end
    end

endmodule

// ----- rtl/led_and_seven_segment_shift_driver.sv -----
// LED and seven-segment shift driver, top level. Clear, set-led and set-digit
// take effect at the edge they are accepted, one transaction per cycle.
// Apply snapshots the image; the serializer sends its 24 bits one per cycle while
// m_ready is high, each snapshot passing the queue register and then the shift register.
// Up to two snapshots wait in the queue; the input stalls while it is full.
// Synchronous active-low reset clears the image, the queue and the serializer.
module led_and_seven_segment_shift_driver import lsd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [4:0] s_led_index,
    input  logic       s_led_on,
    input  logic       s_digit_select,
    input  logic [3:0] s_digit_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_serial_bit,
    output logic [4:0] m_bit_number,
    output logic       m_latch_last
);

    push_t  push;
    qstat_t qstat;
    image_t rd_data;
    logic   pop;

    lsd_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_led_index    (s_led_index),
        .s_led_on       (s_led_on),
        .s_digit_select (s_digit_select),
        .s_digit_value  (s_digit_value),
        .qstat          (qstat),
        .push           (push)
    );

    lsd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .rd_data (rd_data),
        .qstat   (qstat)
    );

    lsd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rd_data      (rd_data),
        .qstat        (qstat),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_serial_bit (m_serial_bit),
        .m_bit_number (m_bit_number),
        .m_latch_last (m_latch_last)
    );

    // A non-final bit taken is followed by the next bit number
    a_bit_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_latch_last |=>
            m_valid && (m_bit_number == $past(m_bit_number) + 5'd1))
        else $error("serial bit number did not advance");

    // Queue never overfills
    a_queue_level: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.level <= 2'(QDEPTH))
        else $error("snapshot queue overflow");

    // No push into a full queue, no pop from an empty one
    a_queue_use: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push.valid && qstat.full) && !(pop && qstat.empty))
        else $error("snapshot queue misuse");

    // A waiting snapshot starts at bit zero right after the latch bit
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_latch_last && !qstat.empty |=>
            m_valid && (m_bit_number == 5'd0))
        else $error("queued snapshot did not start at bit zero");

endmodule
